/* hw/rtl/mbce_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbce_pkg
// Shared types and constants of the middle button chord emulator.
// ----------------------------------------------------------------------------
package mbce_pkg;

	localparam int BUTTON_BITS = 8;
	localparam int BTN_W       = 8;
	localparam int TIME_W      = 64;
	localparam int COUNT_W     = 4;
	localparam int CFG_IDX_W   = 2;

	// buttons above BUTTON_BITS are never reported
	localparam logic [BTN_W-1:0] BTN_MASK =
		BTN_W'((65'd1 << BUTTON_BITS) - 65'd1);

	localparam logic [BTN_W-1:0]   BTN_LR     = 8'h03;
	localparam logic [BTN_W-1:0]   BTN_MIDDLE = 8'h04;
	localparam logic [COUNT_W-1:0] MIN_EMU_COUNT = 4'd2;

	localparam logic [TIME_W-1:0]  WINDOW_RESET = 64'd100000000;
	localparam logic [COUNT_W-1:0] COUNT_RESET  = 4'd2;

	typedef enum logic [1:0] {
		KIND_TRACKPAD = 2'd0,
		KIND_TIMER    = 2'd1,
		KIND_CANCEL   = 2'd2,
		KIND_PASS     = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		TIMER_NONE   = 2'd0,
		TIMER_ARM    = 2'd1,
		TIMER_CANCEL = 2'd2
	} timer_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENABLE       = 2'd0,
		CFG_BUTTON_COUNT = 2'd1,
		CFG_TP_DISABLED  = 2'd2,
		CFG_WINDOW       = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic                fake_middle_enable;
		logic [COUNT_W-1:0]  button_count;
		logic                touchpad_disabled;
		logic [TIME_W-1:0]   chord_window_ns;
	} cfg_t;

endpackage

/* hw/rtl/mbce_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbce_if
// Valid/ready channels of the chord emulator: input items, results, config.
// ----------------------------------------------------------------------------
interface mbce_item_if;
	logic                          valid;
	logic                          ready;
	mbce_pkg::kind_t               kind;
	logic [mbce_pkg::BTN_W-1:0]    buttons;
	logic [mbce_pkg::TIME_W-1:0]   time_ns;

	modport source (output valid, kind, buttons, time_ns, input ready);
	modport sink   (input valid, kind, buttons, time_ns, output ready);
endinterface

interface mbce_result_if;
	logic                          valid;
	logic                          ready;
	logic [mbce_pkg::BTN_W-1:0]    out_buttons;
	logic                          emit_late_report;
	logic [mbce_pkg::BTN_W-1:0]    late_buttons;
	mbce_pkg::timer_t              timer_action;

	modport source (output valid, out_buttons, emit_late_report, late_buttons,
		timer_action, input ready);
	modport sink   (input valid, out_buttons, emit_late_report, late_buttons,
		timer_action, output ready);
endinterface

interface mbce_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mbce_pkg::CFG_IDX_W-1:0]  index;
	logic [mbce_pkg::TIME_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/middle_button_chord_emulator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// middle_button_chord_emulator
// Left plus right pressed together within a window is reported as middle.
// ----------------------------------------------------------------------------
// path: an accepted input beat is held in the input register, and its result is
//   registered in the result register once that register is free or being read
// throughput: one item per cycle; while a result waits, one more beat is taken
//   into the input register before the input stalls
// reset (arst_n low): idle mode, no pending buttons, press time zero, both
//   pipeline registers empty, config back to enable=1 count=2 tp=0 window=100 ms
module middle_button_chord_emulator (
	input  logic          clk,
	input  logic          arst_n,
	mbce_item_if.sink     in_ch,
	mbce_result_if.source out_ch,
	mbce_cfg_if.sink      cfg_ch
);
	import mbce_pkg::*;

	cfg_t               cfg;
	logic               valid_s1;
	kind_t              kind_s1;
	logic [BTN_W-1:0]   buttons_s1;
	logic [TIME_W-1:0]  time_s1;
	logic               advance;

	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			kind_s1    <= in_ch.kind;
			buttons_s1 <= in_ch.buttons;
			time_s1    <= in_ch.time_ns;
		end
	end

	mbce_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	mbce_chord_fsm u_fsm (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.item_valid   (valid_s1),
		.item_kind    (kind_s1),
		.item_buttons (buttons_s1),
		.item_time    (time_s1),
		.advance      (advance),
		.out_ch       (out_ch)
	);

endmodule

/* hw/rtl/mbce_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbce_cfg_regs
// Configuration register file, one write beat per cycle.
// ----------------------------------------------------------------------------
module mbce_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	mbce_cfg_if.sink         cfg_ch,
	output mbce_pkg::cfg_t   cfg
);
	import mbce_pkg::*;

	cfg_t cfg_q;

	assign cfg_ch.ready = 1'b1;
	assign cfg          = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fake_middle_enable <= 1'b1;
			cfg_q.button_count       <= COUNT_RESET;
			cfg_q.touchpad_disabled  <= 1'b0;
			cfg_q.chord_window_ns    <= WINDOW_RESET;
		end else if (cfg_ch.valid) begin
			unique case (cfg_idx_t'(cfg_ch.index))
				CFG_ENABLE:       cfg_q.fake_middle_enable <= cfg_ch.data[0];
				CFG_BUTTON_COUNT: cfg_q.button_count       <= cfg_ch.data[COUNT_W-1:0];
				CFG_TP_DISABLED:  cfg_q.touchpad_disabled  <= cfg_ch.data[0];
				CFG_WINDOW:       cfg_q.chord_window_ns    <= cfg_ch.data;
				default: ;
			endcase
		end
	end

endmodule

/* hw/rtl/mbce_chord_fsm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbce_chord_fsm
// Chord state machine with its result register; one item per cycle while the result channel does not stall.
// ----------------------------------------------------------------------------
module mbce_chord_fsm (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mbce_pkg::cfg_t                 cfg,
	input  logic                           item_valid,
	input  mbce_pkg::kind_t                item_kind,
	input  logic [mbce_pkg::BTN_W-1:0]     item_buttons,
	input  logic [mbce_pkg::TIME_W-1:0]    item_time,
	output logic                           advance,
	mbce_result_if.source                  out_ch
);
	import mbce_pkg::*;

	typedef enum logic [2:0] {
		MODE_IDLE      = 3'd0,
		MODE_WAIT_TWO  = 3'd1,
		MODE_MIDDLE    = 3'd2,
		MODE_WAIT_NONE = 3'd3,
		MODE_NOOP      = 3'd4
	} mode_t;

	mode_t              mode_q, mode_d;
	logic [BTN_W-1:0]   pend_q, pend_d;
	logic [TIME_W-1:0]  press_q, press_d;
	logic               out_valid_q;
	logic [BTN_W-1:0]   out_btn_q, late_q;
	logic               emit_q;
	timer_t             tact_q;

	logic [BTN_W-1:0]   btn, out_btn, late;
	logic [TIME_W-1:0]  elapsed;
	logic               expired, bypass, emit;
	timer_t             tact;

	assign advance = item_valid && (!out_valid_q || out_ch.ready);

	assign out_ch.valid            = out_valid_q;
	assign out_ch.out_buttons      = out_btn_q;
	assign out_ch.emit_late_report = emit_q;
	assign out_ch.late_buttons     = late_q;
	assign out_ch.timer_action     = tact_q;

	always_comb begin
		btn     = item_buttons & BTN_MASK;
		elapsed = item_time - press_q;
		expired = (item_kind == KIND_TIMER) || (item_kind == KIND_CANCEL) ||
			(elapsed > cfg.chord_window_ns);
		bypass  = !cfg.fake_middle_enable || (cfg.button_count <= MIN_EMU_COUNT) ||
			(cfg.touchpad_disabled && item_kind == KIND_TRACKPAD);

		mode_d  = mode_q;
		pend_d  = pend_q;
		press_d = press_q;
		emit    = 1'b0;
		late    = '0;
		tact    = TIMER_NONE;

		if (!bypass) begin
			unique case (mode_q)
				MODE_IDLE: begin
					if (item_kind != KIND_CANCEL) begin
						if (btn[2]) begin
							mode_d = MODE_NOOP;
						end else if (btn == BTN_LR) begin
							mode_d = MODE_MIDDLE;
						end else if (btn != '0) begin
							pend_d  = btn;
							press_d = item_time;
							tact    = TIMER_ARM;
							mode_d  = MODE_WAIT_TWO;
						end
					end
				end
				MODE_WAIT_TWO: begin
					if (!expired && btn == BTN_LR) begin
						pend_d = '0;
						tact   = TIMER_CANCEL;
						mode_d = MODE_MIDDLE;
					end else if (expired || btn != pend_q) begin
						// held-back single press goes out late on a timer item, or else unless still held
						if (item_kind == KIND_TIMER || (btn & pend_q) == '0) begin
							emit = 1'b1;
							late = btn | pend_q;
						end
						pend_d = '0;
						tact   = TIMER_CANCEL;
						mode_d = (btn == '0) ? MODE_IDLE : MODE_NOOP;
					end
				end
				MODE_MIDDLE: begin
					if (btn == '0) begin
						mode_d = MODE_IDLE;
					end else if ((btn & BTN_LR) != BTN_LR) begin
						pend_d  = btn;
						press_d = item_time;
						tact    = TIMER_ARM;
						mode_d  = MODE_WAIT_NONE;
					end
				end
				MODE_WAIT_NONE: begin
					if (!expired && btn == '0) begin
						pend_d = '0;
						tact   = TIMER_CANCEL;
						mode_d = MODE_IDLE;
					end else if (expired || btn != pend_q) begin
						if (item_kind == KIND_TIMER) begin
							emit = 1'b1;
							late = btn | pend_q;
						end
						pend_d = '0;
						tact   = TIMER_CANCEL;
						mode_d = (btn == '0) ? MODE_IDLE : MODE_NOOP;
					end
				end
				default: begin
					if (btn == '0) mode_d = MODE_IDLE;
				end
			endcase
		end

		out_btn = btn;
		if (!bypass) begin
			if (mode_d == MODE_MIDDLE) begin
				out_btn = BTN_MIDDLE;
			end else if (mode_d == MODE_WAIT_TWO || mode_d == MODE_WAIT_NONE) begin
				out_btn = btn & ~BTN_LR;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			pend_q      <= '0;
			press_q     <= '0;
			out_valid_q <= 1'b0;
			out_btn_q   <= '0;
			emit_q      <= 1'b0;
			late_q      <= '0;
			tact_q      <= TIMER_NONE;
		end else if (advance) begin
			mode_q      <= mode_d;
			pend_q      <= pend_d;
			press_q     <= press_d;
			out_valid_q <= 1'b1;
			out_btn_q   <= out_btn;
			emit_q      <= emit;
			late_q      <= late;
			tact_q      <= tact;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* hw/rtl/mbce_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbce_checker
// Port-level checks of the chord emulator, bound to the top level.
// ----------------------------------------------------------------------------
module mbce_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         out_valid,
	input  logic                         out_ready,
	input  logic [mbce_pkg::BTN_W-1:0]   out_buttons,
	input  logic                         emit_late_report,
	input  logic [mbce_pkg::BTN_W-1:0]   late_buttons,
	input  logic [1:0]                   timer_action
);
	import mbce_pkg::*;

	// a stalled result beat keeps its buttons, late buttons and timer action
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_buttons) &&
			$stable(late_buttons) && $stable(timer_action))
		else $error("stalled result beat changed");

	// no late report, no late buttons
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !emit_late_report |-> late_buttons == '0)
		else $error("late buttons without late report");

	// a late report only comes when a wait state is left
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && emit_late_report |-> timer_action == TIMER_CANCEL)
		else $error("late report without timer cancel");

	// arming the timer means a wait state, where left and right are masked
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && timer_action == TIMER_ARM |-> (out_buttons & BTN_LR) == '0)
		else $error("left or right shown while the chord timer runs");

endmodule

bind middle_button_chord_emulator mbce_checker u_mbce_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_ch.valid),
	.out_ready        (out_ch.ready),
	.out_buttons      (out_ch.out_buttons),
	.emit_late_report (out_ch.emit_late_report),
	.late_buttons     (out_ch.late_buttons),
	.timer_action     (out_ch.timer_action)
);
